[design/ostt_pkg.sv]
// Shared types and codes for the one-shot timer table.
package ostt_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ostt_state_t;

    // Operation codes carried in the input item.
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_REPORT   = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_FIRE      = 3'd0;
    localparam logic [2:0] KIND_SCHEDULED = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_COUNTS    = 3'd5;
    localparam logic [2:0] KIND_OUTCOME   = 3'd6;

    // Per-slot task status codes.
    localparam logic [2:0] TS_PENDING   = 3'd0;
    localparam logic [2:0] TS_RUNNING   = 3'd1;
    localparam logic [2:0] TS_DONE      = 3'd2;
    localparam logic [2:0] TS_FAILED    = 3'd3;
    localparam logic [2:0] TS_CANCELLED = 3'd4;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 136;

endpackage

[design/one_shot_timer_table_top.sv]
// One-shot timer table: slot memories, per-item scan sequencer and result register.
//
// A table of up to TASK_SLOTS one-shot timers held in synchronous memories (deadline,
// status, key and target). Each input item carries the current time. The block first walks
// every used slot, one slot read per cycle from the memories unless a due slot is waiting
// for the result register, firing each pending task whose deadline has arrived (one fire
// item per task, in slot order); in the same walk it finds the first pending key match for
// a cancel, counts pending tasks for a query and settles a reported outcome. It then gives
// the operation's own result item, marked by tlast, and for a schedule appends the new
// task to the next free slot. The walk reads the slots one at a time through the single
// read port of the slot memories; a stalled result channel holds the walk or the result.
// Only one item is in work at a time and s_axis_tready is high while the block is waiting
// for the next one. The limit register may be written at any idle moment through cfg_we
// and cfg_wdata.
module one_shot_timer_table_top #(
    parameter int TASK_SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: task limit.
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0 up: now_time[31:0], task_key[63:32], target_handle[79:64],
    // time_value[111:80], time_is_absolute[112], report_slot[117:113], report_ok[118],
    // zero pad[119].
    input  logic [ostt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0 up: task_id[5:0], fire_target[21:6], fire_key[53:22],
    // eta_seconds[85:54], pending_count[91:86], finished_count[97:92],
    // executed_count[129:98], zero pad[135:130].
    output logic [ostt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: kind[2:0].
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    // Slot index width and count width (count can hold TASK_SLOTS itself).
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

    // Slot memories, one read and one write port each, read data registered.
    logic [31:0] deadline_mem [TASK_SLOTS];
    logic [2:0]  status_mem   [TASK_SLOTS];
    logic [31:0] key_mem      [TASK_SLOTS];
    logic [15:0] target_mem   [TASK_SLOTS];

    logic [31:0] rd_deadline_reg;
    logic [2:0]  rd_status_reg;
    logic [31:0] rd_key_reg;
    logic [15:0] rd_target_reg;

    logic [IW-1:0] raddr;
    logic          st_we;
    logic [IW-1:0] st_waddr;
    logic [2:0]    st_wdata;
    logic          ent_we;

    ostt_pkg::ostt_state_t state_reg, state_next;

    // Item held while in work.
    logic [1:0]  op_reg, op_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] tgt_reg, tgt_next;
    logic [31:0] dl_reg, dl_next;
    logic [4:0]  rslot_reg, rslot_next;
    logic        ok_reg, ok_next;

    // Table control state.
    logic [CW-1:0] used_reg, used_next;
    logic [31:0]   fired_reg, fired_next;
    logic [5:0]    limit_reg, limit_next;

    // Scan sequencer.
    logic [CW-1:0] issue_reg, issue_next;
    logic          eval_valid_reg, eval_valid_next;
    logic [IW-1:0] eval_idx_reg, eval_idx_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic          cfound_reg, cfound_next;
    logic [IW-1:0] cidx_reg, cidx_next;
    logic          rhit_reg, rhit_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [5:0]  out_id_reg, out_id_next;
    logic [15:0] out_tgt_reg, out_tgt_next;
    logic [31:0] out_key_reg, out_key_next;
    logic [31:0] out_eta_reg, out_eta_next;
    logic [5:0]  out_pend_reg, out_pend_next;
    logic [5:0]  out_fin_reg, out_fin_next;
    logic [31:0] out_exec_reg, out_exec_next;
    logic        out_last_reg, out_last_next;

    // Input field views.
    logic [31:0] in_now, in_key, in_tval;
    logic [15:0] in_tgt;
    logic        in_abs, in_ok;
    logic [4:0]  in_rslot;
    logic [32:0] rel_sum;
    logic [31:0] in_deadline;

    assign in_now   = s_axis_tdata[31:0];
    assign in_key   = s_axis_tdata[63:32];
    assign in_tgt   = s_axis_tdata[79:64];
    assign in_tval  = s_axis_tdata[111:80];
    assign in_abs   = s_axis_tdata[112];
    assign in_rslot = s_axis_tdata[117:113];
    assign in_ok    = s_axis_tdata[118];

    // A relative deadline saturates at the top of the time range.
    assign rel_sum     = {1'b0, in_now} + {1'b0, in_tval};
    assign in_deadline = in_abs ? in_tval : (rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0]);

    // Evaluation of the slot whose memory words are in the read registers.
    logic       ev_pending, ev_due, ev_post_pending, ev_cancel, ev_report;
    logic [2:0] ev_post_status, ev_final;

    assign ev_pending      = (rd_status_reg == ostt_pkg::TS_PENDING);
    assign ev_due          = ev_pending && (now_reg >= rd_deadline_reg);
    assign ev_post_pending = ev_pending && !ev_due;
    assign ev_cancel       = (op_reg == ostt_pkg::OP_CANCEL) && !cfound_reg
                             && ev_post_pending && (rd_key_reg == key_reg);
    assign ev_post_status  = ev_due ? ostt_pkg::TS_RUNNING
                           : (ev_cancel ? ostt_pkg::TS_CANCELLED : rd_status_reg);
    assign ev_report       = (op_reg == ostt_pkg::OP_REPORT)
                             && (rslot_reg == 5'(eval_idx_reg))
                             && (ev_post_status == ostt_pkg::TS_RUNNING);
    assign ev_final        = ev_report ? (ok_reg ? ostt_pkg::TS_DONE : ostt_pkg::TS_FAILED)
                           : ev_post_status;

    logic out_free;
    logic stall;
    logic sched_full;

    assign out_free   = !out_valid_reg || m_axis_tready;
    // A due slot must wait until the result register can take its fire item.
    assign stall      = eval_valid_reg && ev_due && !out_free;
    assign sched_full = (6'(used_reg) >= limit_reg) || (used_reg >= SLOTS_C);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        key_next        = key_reg;
        tgt_next        = tgt_reg;
        dl_next         = dl_reg;
        rslot_next      = rslot_reg;
        ok_next         = ok_reg;
        used_next       = used_reg;
        fired_next      = fired_reg;
        limit_next      = cfg_we ? cfg_wdata : limit_reg;
        issue_next      = issue_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        pend_next       = pend_reg;
        cfound_next     = cfound_reg;
        cidx_next       = cidx_reg;
        rhit_next       = rhit_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_tgt_next    = out_tgt_reg;
        out_key_next    = out_key_reg;
        out_eta_next    = out_eta_reg;
        out_pend_next   = out_pend_reg;
        out_fin_next    = out_fin_reg;
        out_exec_next   = out_exec_reg;
        out_last_next   = out_last_reg;

        raddr           = issue_reg[IW-1:0];
        st_we           = 1'b0;
        st_waddr        = eval_idx_reg;
        st_wdata        = ev_final;
        ent_we          = 1'b0;
        s_axis_tready   = 1'b0;

        unique case (state_reg)
            ostt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    op_next         = s_axis_tuser;
                    now_next        = in_now;
                    key_next        = in_key;
                    tgt_next        = in_tgt;
                    dl_next         = in_deadline;
                    rslot_next      = in_rslot;
                    ok_next         = in_ok;
                    issue_next      = '0;
                    eval_valid_next = 1'b0;
                    pend_next       = '0;
                    cfound_next     = 1'b0;
                    rhit_next       = 1'b0;
                    state_next      = (used_reg != '0) ? ostt_pkg::ST_SCAN
                                                       : ostt_pkg::ST_FINISH;
                end
            end

            ostt_pkg::ST_SCAN: begin
                if (stall) begin
                    // Re-read the waiting slot so its words stay in the read registers.
                    raddr = eval_idx_reg;
                end else begin
                    if (issue_reg < used_reg) begin
                        raddr           = issue_reg[IW-1:0];
                        issue_next      = issue_reg + 1'b1;
                        eval_valid_next = 1'b1;
                        eval_idx_next   = issue_reg[IW-1:0];
                    end else begin
                        eval_valid_next = 1'b0;
                        if (!eval_valid_reg) begin
                            state_next = ostt_pkg::ST_FINISH;
                        end
                    end

                    if (eval_valid_reg) begin
                        st_we = (ev_final != rd_status_reg);
                        if (ev_post_pending && !ev_cancel) begin
                            pend_next = pend_reg + 1'b1;
                        end
                        if (ev_cancel) begin
                            cfound_next = 1'b1;
                            cidx_next   = eval_idx_reg;
                        end
                        if (ev_report) begin
                            rhit_next = 1'b1;
                        end
                        if (ev_due) begin
                            if (fired_reg != 32'hFFFF_FFFF) begin
                                fired_next = fired_reg + 32'd1;
                            end
                            out_valid_next = 1'b1;
                            out_kind_next  = ostt_pkg::KIND_FIRE;
                            out_id_next    = 6'(eval_idx_reg) + 6'd1;
                            out_tgt_next   = rd_target_reg;
                            out_key_next   = rd_key_reg;
                            out_eta_next   = '0;
                            out_pend_next  = '0;
                            out_fin_next   = '0;
                            out_exec_next  = '0;
                            out_last_next  = 1'b0;
                        end
                    end
                end
            end

            ostt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = ostt_pkg::KIND_OUTCOME;
                    out_id_next    = '0;
                    out_tgt_next   = '0;
                    out_key_next   = '0;
                    out_eta_next   = '0;
                    out_pend_next  = '0;
                    out_fin_next   = '0;
                    out_exec_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ostt_pkg::ST_IDLE;
                    unique case (op_reg)
                        ostt_pkg::OP_SCHEDULE: begin
                            if (sched_full) begin
                                out_kind_next = ostt_pkg::KIND_FULL;
                            end else begin
                                ent_we        = 1'b1;
                                st_we         = 1'b1;
                                st_waddr      = used_reg[IW-1:0];
                                st_wdata      = ostt_pkg::TS_PENDING;
                                used_next     = used_reg + 1'b1;
                                out_kind_next = ostt_pkg::KIND_SCHEDULED;
                                out_id_next   = 6'(used_reg) + 6'd1;
                                out_eta_next  = (dl_reg > now_reg) ? (dl_reg - now_reg)
                                                                   : 32'd0;
                            end
                        end
                        ostt_pkg::OP_CANCEL: begin
                            if (cfound_reg) begin
                                out_kind_next = ostt_pkg::KIND_CANCELLED;
                                out_id_next   = 6'(cidx_reg) + 6'd1;
                                out_key_next  = key_reg;
                            end else begin
                                out_kind_next = ostt_pkg::KIND_NOT_FOUND;
                            end
                        end
                        ostt_pkg::OP_QUERY: begin
                            out_kind_next = ostt_pkg::KIND_COUNTS;
                            out_pend_next = 6'(pend_reg);
                            out_fin_next  = 6'(used_reg - pend_reg);
                            out_exec_next = fired_reg;
                        end
                        ostt_pkg::OP_REPORT: begin
                            if (rhit_reg) begin
                                out_id_next = 6'(rslot_reg) + 6'd1;
                            end
                        end
                        default: begin
                            out_kind_next = ostt_pkg::KIND_OUTCOME;
                        end
                    endcase
                end
            end

            default: begin
                state_next = ostt_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            status_mem[st_waddr] <= st_wdata;
        end
        if (ent_we) begin
            deadline_mem[used_reg[IW-1:0]] <= dl_reg;
            key_mem[used_reg[IW-1:0]]      <= key_reg;
            target_mem[used_reg[IW-1:0]]   <= tgt_reg;
        end
        rd_deadline_reg <= deadline_mem[raddr];
        rd_status_reg   <= status_mem[raddr];
        rd_key_reg      <= key_mem[raddr];
        rd_target_reg   <= target_mem[raddr];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ostt_pkg::ST_IDLE;
            used_reg       <= '0;
            fired_reg      <= '0;
            limit_reg      <= 6'd32;
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
            pend_reg       <= '0;
            cfound_reg     <= 1'b0;
            rhit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fired_reg      <= fired_next;
            limit_reg      <= limit_next;
            issue_reg      <= issue_next;
            eval_valid_reg <= eval_valid_next;
            pend_reg       <= pend_next;
            cfound_reg     <= cfound_next;
            rhit_reg       <= rhit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        key_reg       <= key_next;
        tgt_reg       <= tgt_next;
        dl_reg        <= dl_next;
        rslot_reg     <= rslot_next;
        ok_reg        <= ok_next;
        eval_idx_reg  <= eval_idx_next;
        cidx_reg      <= cidx_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_tgt_reg   <= out_tgt_next;
        out_key_reg   <= out_key_next;
        out_eta_reg   <= out_eta_next;
        out_pend_reg  <= out_pend_next;
        out_fin_reg   <= out_fin_next;
        out_exec_reg  <= out_exec_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_exec_reg, out_fin_reg, out_pend_reg, out_eta_reg,
                            out_key_reg, out_tgt_reg, out_id_reg};

endmodule
